// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl/core modules
// each macro samples on clk_i; the module that uses it must have clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/tcpopt_pkg.sv =====
// shared types and constants for the tcp option area parser
// no dependencies
package tcpopt_pkg;

  // default limit on option area length in bytes
  localparam int unsigned MAX_AREA_BYTES_DEF = 64;

  // option kind codes
  localparam logic [7:0] KIND_END       = 8'd0;
  localparam logic [7:0] KIND_NOP       = 8'd1;
  localparam logic [7:0] KIND_MSS       = 8'd2;
  localparam logic [7:0] KIND_WSCALE    = 8'd3;
  localparam logic [7:0] KIND_SACK_PERM = 8'd4;
  localparam logic [7:0] KIND_SACK      = 8'd5;
  localparam logic [7:0] KIND_TSTAMP    = 8'd8;
  localparam logic [7:0] KIND_COOKIE    = 8'd34;

  // expected option lengths
  localparam logic [7:0] LEN_MIN        = 8'd2;
  localparam logic [7:0] LEN_MSS        = 8'd4;
  localparam logic [7:0] LEN_WSCALE     = 8'd3;
  localparam logic [7:0] LEN_SACK_PERM  = 8'd2;
  localparam logic [7:0] LEN_TSTAMP     = 8'd10;
  localparam logic [7:0] LEN_COOKIE_MAX = 8'd16;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PH_KIND = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_STOP = 4'b1000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  // input word
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0]  kind_byte;
    logic [7:0]  len_byte;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic        value_valid;
    logic [1:0]  block_index;
    logic        last_of_option;
    logic        list_done;
    status_e     status;
  } out_word_t;

  // running parse state (area position kept apart, its width follows the limit)
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  kind;
    logic [7:0]  len;
    logic [7:0]  body_cnt;
    logic [31:0] acc1;
    logic [31:0] acc2;
    logic [1:0]  sack_cnt;
  } parse_state_t;

endpackage

// ===== rtl/core/tcpopt_step.sv =====
// next-state and result logic for one option byte
// depends on tcpopt_pkg
module tcpopt_step import tcpopt_pkg::*; #(
  parameter int unsigned MaxAreaBytes = MAX_AREA_BYTES_DEF,
  parameter int unsigned PosW         = $clog2(MaxAreaBytes + 1)
) (
  input  parse_state_t    state_i,
  input  logic [PosW-1:0] pos_i,
  input  in_word_t        in_word_i,
  output parse_state_t    state_o,
  output logic            res_valid_o,
  output out_word_t       res_o
);

  // result for a finished option
  function automatic out_word_t finish_f(logic [7:0] kind, logic [7:0] len,
                                         logic [31:0] a1, logic [31:0] a2,
                                         logic [1:0] sack, logic area_end);
    out_word_t r;
    logic      ok;
    r = '0;
    ok = 1'b0;
    r.kind_byte      = kind;
    r.len_byte       = len;
    r.last_of_option = 1'b1;
    r.list_done      = area_end;
    r.status         = ST_OK;
    case (kind)
      KIND_MSS: begin
        ok = (len == LEN_MSS);
        r.value_first = a1;
      end
      KIND_WSCALE: begin
        ok = (len == LEN_WSCALE);
        r.value_first = a1;
      end
      KIND_SACK_PERM: begin
        ok = (len == LEN_SACK_PERM);
      end
      KIND_TSTAMP: begin
        ok = (len == LEN_TSTAMP);
        r.value_first  = a1;
        r.value_second = a2;
      end
      KIND_COOKIE: begin
        ok = (len > LEN_MIN) && (len <= LEN_COOKIE_MAX);
        r.value_first  = a1;
        r.value_second = {24'd0, len - LEN_MIN};
      end
      KIND_SACK: begin
        r.block_index = sack;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      r.value_first  = '0;
      r.value_second = '0;
    end
    r.value_valid = ok;
    return r;
  endfunction

  // result for an option cut off by the end of the area
  function automatic out_word_t trunc_f(logic [7:0] kind, logic [7:0] len,
                                        logic [1:0] sack);
    out_word_t r;
    r = '0;
    r.kind_byte      = kind;
    r.len_byte       = len;
    r.block_index    = (kind == KIND_SACK) ? sack : 2'd0;
    r.last_of_option = 1'b1;
    r.list_done      = 1'b1;
    r.status         = ST_TRUNC;
    return r;
  endfunction

  logic [7:0]  b;
  logic        last;
  logic        area_end;
  logic [2:0]  k;
  logic [8:0]  bc1;
  logic [7:0]  len_m2;
  logic        done;
  logic [31:0] acc1_n;
  logic [31:0] acc2_n;

  assign b        = in_word_i.opt_byte;
  assign last     = in_word_i.last_byte;
  assign area_end = last || (pos_i >= PosW'(MaxAreaBytes - 1));
  assign k        = state_i.body_cnt[2:0];
  assign bc1      = {1'b0, state_i.body_cnt} + 9'd1;
  assign len_m2   = state_i.len - LEN_MIN;
  assign done     = (bc1 == {1'b0, len_m2});

  // body byte folded into the accumulators; a cookie keeps the area position of its first body byte instead
  always_comb begin
    acc1_n = state_i.acc1;
    acc2_n = state_i.acc2;
    if (state_i.kind == KIND_COOKIE) begin
      if (state_i.body_cnt == 8'd0) acc1_n = 32'(pos_i);
    end else if (!k[2]) begin
      acc1_n = {state_i.acc1[23:0], b};
    end else begin
      acc2_n = {state_i.acc2[23:0], b};
    end
  end

  // phase walk and result selection
  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_i.phase)
      PH_KIND: begin
        if (b == KIND_END) begin
          res_valid_o          = 1'b1;
          res_o.kind_byte      = KIND_END;
          res_o.last_of_option = 1'b1;
          res_o.list_done      = 1'b1;
          res_o.status         = ST_END;
          state_o.phase        = PH_STOP;
        end else if (b == KIND_NOP) begin
          res_valid_o          = 1'b1;
          res_o.kind_byte      = KIND_NOP;
          res_o.len_byte       = 8'd1;
          res_o.value_valid    = 1'b1;
          res_o.last_of_option = 1'b1;
          res_o.list_done      = area_end;
          res_o.status         = ST_OK;
        end else begin
          state_o.kind     = b;
          state_o.len      = '0;
          state_o.body_cnt = '0;
          state_o.acc1     = '0;
          state_o.acc2     = '0;
          state_o.sack_cnt = '0;
          state_o.phase    = PH_LEN;
          if (area_end) begin
            res_valid_o = 1'b1;
            res_o       = trunc_f(b, 8'd0, 2'd0);
          end
        end
      end
      PH_LEN: begin
        state_o.len = b;
        if (b < LEN_MIN) begin
          res_valid_o          = 1'b1;
          res_o.kind_byte      = state_i.kind;
          res_o.len_byte       = b;
          res_o.last_of_option = 1'b1;
          res_o.list_done      = 1'b1;
          res_o.status         = ST_BAD;
          state_o.phase        = PH_STOP;
        end else if (b == LEN_MIN) begin
          res_valid_o   = 1'b1;
          res_o         = finish_f(state_i.kind, b, state_i.acc1, state_i.acc2,
                                   state_i.sack_cnt, area_end);
          state_o.phase = PH_KIND;
        end else begin
          state_o.phase = PH_BODY;
          if (area_end) begin
            res_valid_o = 1'b1;
            res_o       = trunc_f(state_i.kind, b, state_i.sack_cnt);
          end
        end
      end
      PH_BODY: begin
        state_o.acc1 = acc1_n;
        state_o.acc2 = acc2_n;
        if (state_i.kind == KIND_SACK && k == 3'd7) begin
          res_valid_o = 1'b1;
          if (!done && area_end) begin
            res_o = trunc_f(state_i.kind, state_i.len, state_i.sack_cnt);
          end else begin
            res_o.kind_byte      = KIND_SACK;
            res_o.len_byte       = state_i.len;
            res_o.value_first    = acc1_n;
            res_o.value_second   = acc2_n;
            res_o.value_valid    = (len_m2[2:0] == 3'd0);
            res_o.block_index    = state_i.sack_cnt;
            res_o.last_of_option = done;
            res_o.list_done      = done && area_end;
            res_o.status         = ST_OK;
            state_o.sack_cnt     = state_i.sack_cnt + 2'd1;
          end
        end else if (done) begin
          res_valid_o = 1'b1;
          res_o       = finish_f(state_i.kind, state_i.len, acc1_n, acc2_n,
                                 state_i.sack_cnt, area_end);
        end else if (area_end) begin
          res_valid_o = 1'b1;
          res_o       = trunc_f(state_i.kind, state_i.len, state_i.sack_cnt);
        end
        state_o.body_cnt = bc1[7:0];
        if (done) state_o.phase = PH_KIND;
      end
      PH_STOP: begin
        state_o.phase = PH_STOP;
      end
      default: begin
        state_o.phase = PH_STOP;
      end
    endcase

    // area boundary overrides the phase
    if (last) begin
      state_o.phase = PH_KIND;
    end else if (area_end) begin
      state_o.phase = PH_STOP;
    end
  end

endmodule

// ===== rtl/core/tcp_option_tlv_parser_core.sv =====
// Latency: a result word is valid on the cycle after the byte that completes it is taken.
// Throughput: one option byte per cycle; a byte is taken whenever the result register
// is empty or being drained in the same cycle.
// Reset: rst_ni low clears the parse state to expecting a kind byte at area position 0
// and empties the result register.
`include "assert_macros.svh"

module tcp_option_tlv_parser_core import tcpopt_pkg::*; #(
  parameter int unsigned MaxAreaBytes = MAX_AREA_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned PosW = $clog2(MaxAreaBytes + 1);

  // parse state after reset: expecting a kind byte, everything else zero
  localparam parse_state_t StateRst = '{
    phase:    PH_KIND,
    kind:     8'd0,
    len:      8'd0,
    body_cnt: 8'd0,
    acc1:     32'd0,
    acc2:     32'd0,
    sack_cnt: 2'd0
  };

  parse_state_t    state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q;
  out_word_t       out_q;
  logic            res_valid;
  out_word_t       res;
  logic            in_acc;

  // a word is taken unless the result register is full and stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  tcpopt_step #(
    .MaxAreaBytes(MaxAreaBytes),
    .PosW        (PosW)
  ) u_step (
    .state_i    (state_q),
    .pos_i      (pos_q),
    .in_word_i  (in_word_i),
    .state_o    (state_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // area position, back to 0 after the final byte of an area, else saturating at the limit
  always_comb begin
    pos_d = pos_q;
    if (in_word_i.last_byte) begin
      pos_d = '0;
    end else if (pos_q < PosW'(MaxAreaBytes)) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
      pos_q   <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // final byte of an area restarts the walk at position 0
  `ASSERT_RST(a_last_restarts,
    in_acc && in_word_i.last_byte |=> state_q.phase == PH_KIND && pos_q == '0)
  // position never passes the area limit
  `ASSERT_RST(a_pos_bound, pos_q <= PosW'(MaxAreaBytes))
  // an empty result register never holds off the input
  `ASSERT_ALWAYS(a_no_idle_stall, !out_valid_q |-> !in_stall_o)
  // a truncated or end result always closes the area
  `ASSERT_RST(a_stop_closes,
    out_valid_q && (out_q.status == ST_TRUNC || out_q.status == ST_END)
      |-> out_q.list_done && out_q.last_of_option)

endmodule

// ===== verif/tb.sv =====
// testbench for tcp_option_tlv_parser_core: directed and random option areas with bursty input and stalled output
// predicts every result word from its own copy of the parse state; depends on tcpopt_pkg and the core
`timescale 1ns / 100ps

module tb import tcpopt_pkg::*;;

  localparam int AREA_MAX    = MAX_AREA_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int AREA_TARGET = 1900;

  typedef logic [7:0] byte_list_t[$];

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word = '0;
  logic      out_valid_o;
  logic      out_stall = 1'b0;
  out_word_t out_word_o;

  // words waiting to be sent and result words waiting to arrive
  in_word_t  area_bytes_q[$];
  out_word_t expected_options[$];

  // parser state as predicted
  phase_e      phase = PH_KIND;
  logic [7:0]  opt_kind = '0;
  logic [7:0]  opt_len = '0;
  logic [7:0]  body_cnt = '0;
  logic [31:0] acc_first = '0;
  logic [31:0] acc_second = '0;
  logic [1:0]  sack_cnt = '0;
  int          area_pos = 0;

  int err_cnt = 0;
  int cyc = 0;
  int words_sent = 0;
  int words_total = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_hold = 0;
  logic stall_val = 1'b0;

  tcp_option_tlv_parser_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cyc, msg);
    err_cnt++;
  endtask

  task automatic expect_word(input logic [7:0] kind, input logic [7:0] len,
                             input logic [31:0] v1, input logic [31:0] v2,
                             input logic ok, input logic [1:0] idx, input logic opt_last,
                             input logic area_last, input status_e st);
    out_word_t w;
    w.kind_byte      = kind;
    w.len_byte       = len;
    w.value_first    = v1;
    w.value_second   = v2;
    w.value_valid    = ok;
    w.block_index    = idx;
    w.last_of_option = opt_last;
    w.list_done      = area_last;
    w.status         = st;
    expected_options.push_back(w);
  endtask

  // option cut off by the end of the area
  task automatic expect_truncated();
    logic [1:0] idx;
    idx = (opt_kind == KIND_SACK) ? sack_cnt : 2'd0;
    expect_word(opt_kind, opt_len, '0, '0, 1'b0, idx, 1'b1, 1'b1, ST_TRUNC);
  endtask

  // option closed by its length
  task automatic expect_closed(input logic at_end);
    logic [31:0] v1;
    logic [31:0] v2;
    logic        ok;
    logic [1:0]  idx;
    v1 = '0;
    v2 = '0;
    ok = 1'b0;
    idx = 2'd0;
    case (opt_kind)
      KIND_MSS: begin
        ok = (opt_len == LEN_MSS);
        v1 = acc_first;
      end
      KIND_WSCALE: begin
        ok = (opt_len == LEN_WSCALE);
        v1 = acc_first;
      end
      KIND_SACK_PERM: ok = (opt_len == LEN_SACK_PERM);
      KIND_TSTAMP: begin
        ok = (opt_len == LEN_TSTAMP);
        v1 = acc_first;
        v2 = acc_second;
      end
      KIND_COOKIE: begin
        ok = (opt_len > LEN_MIN) && (opt_len <= LEN_COOKIE_MAX);
        v1 = acc_first;
        v2 = {24'd0, 8'(opt_len - LEN_MIN)};
      end
      KIND_SACK: idx = sack_cnt;
      default: ;
    endcase
    if (!ok) begin
      v1 = '0;
      v2 = '0;
    end
    expect_word(opt_kind, opt_len, v1, v2, ok, idx, 1'b1, at_end, ST_OK);
  endtask

  // advance the predicted parse state by one taken word
  task automatic parse_option_byte(input in_word_t w);
    logic [7:0] b;
    logic [7:0] nxt_cnt;
    logic       at_end;
    logic       opt_done;
    logic       blk_ok;
    int         pos;
    b = w.opt_byte;
    pos = area_pos;
    at_end = w.last_byte || (pos + 1 >= AREA_MAX);
    case (phase)
      PH_KIND: begin
        if (b == KIND_END) begin
          expect_word(KIND_END, 8'd0, '0, '0, 1'b0, 2'd0, 1'b1, 1'b1, ST_END);
          phase = PH_STOP;
        end else if (b == KIND_NOP) begin
          expect_word(KIND_NOP, 8'd1, '0, '0, 1'b1, 2'd0, 1'b1, at_end, ST_OK);
        end else begin
          opt_kind = b;
          opt_len = '0;
          body_cnt = '0;
          acc_first = '0;
          acc_second = '0;
          sack_cnt = '0;
          if (at_end) expect_truncated();
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_len = b;
        if (b < LEN_MIN) begin
          expect_word(opt_kind, b, '0, '0, 1'b0, 2'd0, 1'b1, 1'b1, ST_BAD);
          phase = PH_STOP;
        end else if (b == LEN_MIN) begin
          expect_closed(at_end);
          phase = PH_KIND;
        end else begin
          if (at_end) expect_truncated();
          phase = PH_BODY;
        end
      end
      PH_BODY: begin
        nxt_cnt = body_cnt + 8'd1;
        opt_done = (nxt_cnt == 8'(opt_len - LEN_MIN));
        // cookie keeps its byte offset, others shift into the two accumulators
        if (opt_kind == KIND_COOKIE) begin
          if (body_cnt == 8'd0) acc_first = 32'(pos);
        end else if (!body_cnt[2]) begin
          acc_first = {acc_first[23:0], b};
        end else begin
          acc_second = {acc_second[23:0], b};
        end
        if (opt_kind == KIND_SACK && body_cnt[2:0] == 3'd7) begin
          if (!opt_done && at_end) begin
            expect_truncated();
          end else begin
            blk_ok = (8'(opt_len - LEN_MIN) & 8'd7) == 8'd0;
            expect_word(KIND_SACK, opt_len, acc_first, acc_second, blk_ok, sack_cnt,
                        opt_done, opt_done && at_end, ST_OK);
            sack_cnt = sack_cnt + 2'd1;
          end
        end else if (opt_done) begin
          expect_closed(at_end);
        end else if (at_end) begin
          expect_truncated();
        end
        body_cnt = nxt_cnt;
        if (opt_done) phase = PH_KIND;
      end
      default: ;
    endcase
    if (w.last_byte) begin
      phase = PH_KIND;
      area_pos = 0;
    end else begin
      if (at_end) phase = PH_STOP;
      if (area_pos < AREA_MAX) area_pos++;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s got %0h want %0h", what, got_v, want_v));
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_options.size() == 0) begin
      report_mismatch($sformatf("unexpected word, kind %0d", got.kind_byte));
    end else begin
      want = expected_options.pop_front();
      check_field("kind_byte", got.kind_byte, want.kind_byte);
      check_field("len_byte", got.len_byte, want.len_byte);
      check_field("value_first", got.value_first, want.value_first);
      check_field("value_second", got.value_second, want.value_second);
      check_field("value_valid", got.value_valid, want.value_valid);
      check_field("block_index", got.block_index, want.block_index);
      check_field("last_of_option", got.last_of_option, want.last_of_option);
      check_field("list_done", got.list_done, want.list_done);
      check_field("status", got.status, want.status);
    end
  endtask

  // append one area, last_byte on its final word
  task automatic queue_area(input byte_list_t a);
    in_word_t w;
    foreach (a[i]) begin
      w.opt_byte = a[i];
      w.last_byte = (i == a.size() - 1);
      area_bytes_q.push_back(w);
    end
  endtask

  // one option, mostly well formed
  task automatic add_option(ref byte_list_t a);
    logic [7:0] kind;
    logic [7:0] len;
    int         pick;
    int         body;
    pick = $urandom_range(0, 19);
    len = 8'd0;
    case (pick)
      0, 1, 2: kind = KIND_NOP;
      3, 4: begin
        kind = KIND_MSS;
        len = LEN_MSS;
      end
      5, 6: begin
        kind = KIND_WSCALE;
        len = LEN_WSCALE;
      end
      7: begin
        kind = KIND_SACK_PERM;
        len = LEN_SACK_PERM;
      end
      8, 9: begin
        kind = KIND_TSTAMP;
        len = LEN_TSTAMP;
      end
      10, 11: begin
        kind = KIND_COOKIE;
        len = 8'($urandom_range(2, 18));
      end
      12, 13, 14: begin
        kind = KIND_SACK;
        len = 8'(2 + 8 * $urandom_range(1, 4));
      end
      15: begin
        // leftover bytes or more than four blocks
        kind = KIND_SACK;
        len = 8'($urandom_range(2, 60));
      end
      16, 17: begin
        kind = 8'($urandom_range(6, 255));
        len = 8'($urandom_range(2, 14));
      end
      18: begin
        kind = 8'($urandom_range(2, 255));
        len = 8'($urandom_range(0, 255));
      end
      default: begin
        // known kind, random length that is often off
        case ($urandom_range(0, 3))
          0: kind = KIND_MSS;
          1: kind = KIND_WSCALE;
          2: kind = KIND_SACK_PERM;
          default: kind = KIND_TSTAMP;
        endcase
        len = 8'($urandom_range(2, 12));
      end
    endcase
    a.push_back(kind);
    if (kind != KIND_NOP) begin
      a.push_back(len);
      body = (len > LEN_MIN) ? int'(len) - 2 : 0;
      if (body > 40) body = 40;
      repeat (body) a.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // one random area: noise, or options that may run past the limit, end early or be cut
  task automatic build_area();
    byte_list_t a;
    int mode;
    int span;
    int cut;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 70)) a.push_back(8'($urandom_range(0, 255)));
    end else begin
      span = (mode == 1) ? $urandom_range(60, 80) : $urandom_range(1, 40);
      while (a.size() < span) add_option(a);
      if ($urandom_range(0, 3) == 0) begin
        a.push_back(KIND_END);
        repeat ($urandom_range(0, 3)) a.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, a.size());
        a = a[0:cut-1];
      end
    end
    queue_area(a);
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        parse_option_byte(in_word);
        words_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (area_bytes_q.size() != 0) begin
          in_valid <= 1'b1;
          in_word <= area_bytes_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, in one of four patterns chosen at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (cyc % 3 == 0);
        default: begin
          if (stall_hold == 0) begin
            stall_hold = $urandom_range(1, 8);
            stall_val = ~stall_val;
          end
          stall_hold--;
          out_stall <= stall_val;
        end
      endcase
    end
  end

  // result words taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) check_word(out_word_o);
  end

  // cycle count and run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout with %0d words still expected", expected_options.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    byte_list_t d;
    // nop, mss, window scale and sack permitted, end of list and two bytes after it
    d = {KIND_NOP, KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WSCALE, LEN_WSCALE, 8'h0E,
         KIND_SACK_PERM, LEN_SACK_PERM, KIND_END, 8'h5A, 8'hA5};
    queue_area(d);
    // length below two
    d = {KIND_MSS, 8'd1};
    queue_area(d);
    // area of one byte, cut before the length
    d = {8'd7};
    queue_area(d);
    // unknown kind cut off in its body
    d = {8'hFE, 8'd5, 8'h00, 8'h00};
    queue_area(d);
    // shortest cookie
    d = {KIND_COOKIE, 8'd3, 8'hAB};
    queue_area(d);
    while (area_bytes_q.size() < AREA_TARGET) build_area();
    words_total = area_bytes_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != words_total) @(posedge clk_i);
    while (expected_options.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
